// ===== hdl/psc_pkg.sv =====
package psc_pkg;

   localparam int RawW   = 16;
   localparam int CntW   = 10;
   localparam int CoefW  = 16;
   localparam int LimW   = 8;
   localparam int KpaW   = 7;
   localparam int WordW  = 32;
   localparam int IdxW   = 3;
   localparam int RawLsb = 6;

   // x*65 for a 10-bit count needs 17 bits
   localparam int ScaledW = 17;
   localparam int KpaQW   = ScaledW - CntW;

   localparam logic [6:0]     KpaScale = 7'd65;
   localparam logic [CntW:0]  KpaDiv   = 11'd1023;
   localparam logic [KpaW-1:0] KpaBase = 7'd50;

   localparam int ShC11 = 14;
   localparam int ShC12 = 11;
   localparam int ShB2  = 15;
   localparam int ShA2  = 16;
   localparam int ShA0  = 10;
   localparam int ShPc  = 13;

   localparam logic [IdxW-1:0] CSR_COEF_A0  = 3'd0;
   localparam logic [IdxW-1:0] CSR_COEF_B1  = 3'd1;
   localparam logic [IdxW-1:0] CSR_COEF_B2  = 3'd2;
   localparam logic [IdxW-1:0] CSR_COEF_C12 = 3'd3;
   localparam logic [IdxW-1:0] CSR_COEF_C11 = 3'd4;
   localparam logic [IdxW-1:0] CSR_COEF_C22 = 3'd5;
   localparam logic [IdxW-1:0] CSR_LOW_LIM  = 3'd6;

   typedef logic signed [WordW-1:0] word_type;
   typedef logic signed [CoefW-1:0] coef_type;
   typedef logic [CntW-1:0]         count_type;

endpackage

// ===== hdl/psc_req_if.sv =====
interface psc_req_if;
   logic                          valid;
   logic                          ready;
   logic [psc_pkg::RawW-1:0]      raw_pressure;
   logic [psc_pkg::RawW-1:0]      raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== hdl/psc_rsp_if.sv =====
interface psc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psc_pkg::CntW-1:0]      comp_count;
   logic [psc_pkg::KpaW-1:0]      pressure_kpa;
   logic                          pressure_low;

   modport source (output valid, output comp_count, output pressure_kpa,
                   output pressure_low, input ready);
   modport sink   (input valid, input comp_count, input pressure_kpa,
                   input pressure_low, output ready);
endinterface

// ===== hdl/pressure_sensor_compensation_core.sv =====
// A req beat is registered in stages 1 to 5 in turn before its rsp beat.
// Throughput: one beat per cycle while rsp is ready; five stages, each
// with a valid bit, and a stage holds only while the stage after it is
// full and stalled. Reset (synchronous, active high) empties the pipeline
// and clears all coefficients and the low-pressure limit to zero.
module pressure_sensor_compensation_core (
   input  logic                         clock,
   input  logic                         reset,
   psc_req_if.sink                      req,
   psc_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [psc_pkg::IdxW-1:0]     csr_index,
   input  logic [psc_pkg::CoefW-1:0]    csr_write_data
);

   // configuration registers
   psc_pkg::coef_type a0_ff, b1_ff, b2_ff, c12_ff, c11_ff, c22_ff;
   logic [psc_pkg::LimW-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_ff    <= '0;
         b1_ff    <= '0;
         b2_ff    <= '0;
         c12_ff   <= '0;
         c11_ff   <= '0;
         c22_ff   <= '0;
         limit_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            psc_pkg::CSR_COEF_A0:  a0_ff  <= csr_write_data;
            psc_pkg::CSR_COEF_B1:  b1_ff  <= csr_write_data;
            psc_pkg::CSR_COEF_B2:  b2_ff  <= csr_write_data;
            psc_pkg::CSR_COEF_C12: c12_ff <= csr_write_data;
            psc_pkg::CSR_COEF_C11: c11_ff <= csr_write_data;
            psc_pkg::CSR_COEF_C22: c22_ff <= csr_write_data;
            psc_pkg::CSR_LOW_LIM:  limit_ff <= csr_write_data[psc_pkg::LimW-1:0];
            default: ;
         endcase
      end
   end

   // valid bits and advance chain
   logic [5:1] v_ff, v_in;
   logic [5:1] adv;

   always_comb begin
      adv[5] = !v_ff[5] || rsp.ready;
      adv[4] = !v_ff[4] || adv[5];
      adv[3] = !v_ff[3] || adv[4];
      adv[2] = !v_ff[2] || adv[3];
      adv[1] = !v_ff[1] || adv[2];
      v_in[1] = adv[1] ? req.valid : v_ff[1];
      v_in[2] = adv[2] ? v_ff[1]   : v_ff[2];
      v_in[3] = adv[3] ? v_ff[2]   : v_ff[3];
      v_in[4] = adv[4] ? v_ff[3]   : v_ff[4];
      v_in[5] = adv[5] ? v_ff[4]   : v_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req.ready = adv[1];

   // stage 1: first products
   psc_pkg::count_type p1_ff, t1_ff, p1_in, t1_in;
   psc_pkg::word_type  m11_ff, m12_ff, m22_ff, m11_in, m12_in, m22_in;

   always_comb begin
      p1_in  = req.raw_pressure[psc_pkg::RawW-1:psc_pkg::RawLsb];
      t1_in  = req.raw_temperature[psc_pkg::RawW-1:psc_pkg::RawLsb];
      m11_in = psc_pkg::word_type'(c11_ff)
               * psc_pkg::word_type'({1'b0, p1_in});
      m12_in = psc_pkg::word_type'(c12_ff)
               * psc_pkg::word_type'({1'b0, t1_in});
      m22_in = psc_pkg::word_type'(c22_ff)
               * psc_pkg::word_type'({1'b0, t1_in});
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p1_ff  <= p1_in;
         t1_ff  <= t1_in;
         m11_ff <= m11_in;
         m12_ff <= m12_in;
         m22_ff <= m22_in;
      end
   end

   // stage 2: a1 and a2
   psc_pkg::count_type p2_ff, t2_ff;
   psc_pkg::word_type  a1_ff, a2_ff, a1_in, a2_in;

   always_comb begin
      psc_pkg::word_type s11, a11, s1, s2;
      s11   = (psc_pkg::word_type'(b1_ff) <<< psc_pkg::ShC11) + m11_ff;
      a11   = s11 >>> psc_pkg::ShC11;
      s1    = (a11 <<< psc_pkg::ShC12) + m12_ff;
      a1_in = s1 >>> psc_pkg::ShC12;
      s2    = (psc_pkg::word_type'(b2_ff) <<< psc_pkg::ShB2) + (m22_ff >>> 1);
      a2_in = s2 >>> psc_pkg::ShA2;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         p2_ff <= p1_ff;
         t2_ff <= t1_ff;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
   end

   // stage 3: second products
   psc_pkg::word_type ma1_ff, ma2_ff, ma1_in, ma2_in;

   always_comb begin
      ma1_in = a1_ff * psc_pkg::word_type'({1'b0, p2_ff});
      ma2_in = a2_ff * psc_pkg::word_type'({1'b0, t2_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         ma1_ff <= ma1_in;
         ma2_ff <= ma2_in;
      end
   end

   // stage 4: y1 and compensated count
   psc_pkg::count_type cnt_ff, cnt_in;

   always_comb begin
      psc_pkg::word_type sy, y1, sp, pc;
      sy     = (psc_pkg::word_type'(a0_ff) <<< psc_pkg::ShA0) + ma1_ff;
      y1     = sy >>> psc_pkg::ShA0;
      sp     = (y1 <<< psc_pkg::ShA0) + ma2_ff;
      pc     = sp >>> psc_pkg::ShPc;
      cnt_in = pc[psc_pkg::CntW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         cnt_ff <= cnt_in;
      end
   end

   // stage 5: kPa = cnt*65/1023 + 50, divide by x>>10 plus one correction
   psc_pkg::count_type     cnt5_ff;
   logic [psc_pkg::KpaW-1:0] kpa_ff, kpa_in;
   logic                   low_ff, low_in;

   always_comb begin
      logic [psc_pkg::ScaledW-1:0] x;
      logic [psc_pkg::KpaQW-1:0]   q0;
      logic [psc_pkg::CntW:0]      r;
      logic [psc_pkg::KpaW-1:0]    q;
      x      = psc_pkg::ScaledW'(cnt_ff) * psc_pkg::ScaledW'(psc_pkg::KpaScale);
      q0     = x[psc_pkg::ScaledW-1:psc_pkg::CntW];
      r      = {1'b0, x[psc_pkg::CntW-1:0]} + (psc_pkg::CntW+1)'(q0);
      q      = psc_pkg::KpaW'(q0) + psc_pkg::KpaW'(r >= psc_pkg::KpaDiv);
      kpa_in = q + psc_pkg::KpaBase;
      low_in = {1'b0, kpa_in} <= limit_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         cnt5_ff <= cnt_ff;
         kpa_ff  <= kpa_in;
         low_ff  <= low_in;
      end
   end

   assign rsp.valid        = v_ff[5];
   assign rsp.comp_count   = cnt5_ff;
   assign rsp.pressure_kpa = kpa_ff;
   assign rsp.pressure_low = low_ff;

endmodule

// ===== hdl/psc_checker.sv =====
module psc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [psc_pkg::CntW-1:0]   rsp_comp_count,
   input logic [psc_pkg::KpaW-1:0]   rsp_pressure_kpa,
   input logic                       rsp_pressure_low
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_comp_count)
         && $stable(rsp_pressure_kpa) && $stable(rsp_pressure_low))
      else $error("rsp beat changed while stalled");

   // kPa follows the count
   a_kpa_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_pressure_kpa)
         == (32'(rsp_comp_count) * 32'd65) / 32'd1023 + 32'd50)
      else $error("pressure_kpa does not match comp_count");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // no back pressure at the output means full rate at the input
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp is ready");

endmodule

bind pressure_sensor_compensation_core psc_checker u_psc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_comp_count   (rsp.comp_count),
   .rsp_pressure_kpa (rsp.pressure_kpa),
   .rsp_pressure_low (rsp.pressure_low)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam logic [psc_pkg::IdxW-1:0] CsrUnused = 3'd7;
   localparam int HoldOffCycles = 250;
   localparam int PhaseBeats = 150;

   typedef struct packed {
      logic [psc_pkg::CntW-1:0] comp_count;
      logic [psc_pkg::KpaW-1:0] pressure_kpa;
      logic                     pressure_low;
   } reading_type;

   typedef struct packed {
      logic [psc_pkg::RawW-1:0] pressure;
      logic [psc_pkg::RawW-1:0] temperature;
   } raw_pair_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                         csr_write_enable;
   logic [psc_pkg::IdxW-1:0]     csr_index;
   logic [psc_pkg::CoefW-1:0]    csr_write_data;

   psc_req_if req_ch ();
   psc_rsp_if rsp_ch ();

   pressure_sensor_compensation_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // calibration mirror
   psc_pkg::word_type cal_a0 = '0, cal_b1 = '0, cal_b2 = '0;
   psc_pkg::word_type cal_c12 = '0, cal_c11 = '0, cal_c22 = '0;
   logic [psc_pkg::LimW-1:0] cal_limit = '0;

   raw_pair_type raw_q[$];
   reading_type  reading_q[$];
   int failures = 0;

   int burst_left = 1;
   int gap_left = 0;
   raw_pair_type send_beat;

   int holds_asked = 0;
   int holds_taken = 0;
   int hold_left = 0;
   int mode_left = 0;
   int stall_tick = 0;
   stall_mode_type stall_mode = READY_ALWAYS;

   reading_type want;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic reading_type compensate(input logic [psc_pkg::RawW-1:0] raw_p, raw_t);
      psc_pkg::word_type p, t, acc, a11, a1, a2, y1, pc;
      int unsigned kpa;
      reading_type r;
      p = raw_p >> psc_pkg::RawLsb;
      t = raw_t >> psc_pkg::RawLsb;
      acc = (cal_b1 <<< psc_pkg::ShC11) + cal_c11 * p;
      a11 = acc >>> psc_pkg::ShC11;
      acc = (a11 <<< psc_pkg::ShC12) + cal_c12 * t;
      a1 = acc >>> psc_pkg::ShC12;
      acc = cal_c22 * t;
      acc = (cal_b2 <<< psc_pkg::ShB2) + (acc >>> 1);
      a2 = acc >>> psc_pkg::ShA2;
      acc = (cal_a0 <<< psc_pkg::ShA0) + a1 * p;
      y1 = acc >>> psc_pkg::ShA0;
      acc = (y1 <<< psc_pkg::ShA0) + a2 * t;
      pc = acc >>> psc_pkg::ShPc;
      r.comp_count = pc[psc_pkg::CntW-1:0];
      kpa = r.comp_count * 65 / 1023 + 50;
      r.pressure_kpa = kpa[psc_pkg::KpaW-1:0];
      r.pressure_low = (kpa <= cal_limit);
      return r;
   endfunction

   function automatic logic [psc_pkg::RawW-1:0] pick_raw();
      case ($urandom_range(0, 15))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'hFFC0;
         3: return 16'h003F;
         default: return psc_pkg::RawW'($urandom);
      endcase
   endfunction

   function automatic psc_pkg::coef_type pick_coef(input int phase);
      if (phase == 0) return 16'sh7FFF;
      if (phase == 1) return 16'sh8000;
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return psc_pkg::coef_type'($urandom_range(0, 127)) - 16'sd64;
         default: return psc_pkg::coef_type'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [psc_pkg::IdxW-1:0] idx,
                            input logic [psc_pkg::CoefW-1:0] data);
      psc_pkg::word_type coef_w;
      coef_w = {{(psc_pkg::WordW-psc_pkg::CoefW){data[psc_pkg::CoefW-1]}}, data};
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         psc_pkg::CSR_COEF_A0:  cal_a0 = coef_w;
         psc_pkg::CSR_COEF_B1:  cal_b1 = coef_w;
         psc_pkg::CSR_COEF_B2:  cal_b2 = coef_w;
         psc_pkg::CSR_COEF_C12: cal_c12 = coef_w;
         psc_pkg::CSR_COEF_C11: cal_c11 = coef_w;
         psc_pkg::CSR_COEF_C22: cal_c22 = coef_w;
         psc_pkg::CSR_LOW_LIM:  cal_limit = data[psc_pkg::LimW-1:0];
         default: ;
      endcase
   endtask

   task automatic load_coefficients(input psc_pkg::coef_type a0, b1, b2, c12, c11, c22,
                                    input logic [psc_pkg::LimW-1:0] limit);
      write_reg(psc_pkg::CSR_COEF_A0, a0);
      write_reg(psc_pkg::CSR_COEF_B1, b1);
      write_reg(psc_pkg::CSR_COEF_B2, b2);
      write_reg(psc_pkg::CSR_COEF_C12, c12);
      write_reg(psc_pkg::CSR_COEF_C11, c11);
      write_reg(psc_pkg::CSR_COEF_C22, c22);
      write_reg(psc_pkg::CSR_LOW_LIM, {8'($urandom), limit});
      write_reg(CsrUnused, 16'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_pair(input logic [psc_pkg::RawW-1:0] raw_p, raw_t);
      raw_q.push_back('{pressure: raw_p, temperature: raw_t});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (raw_q.size() != 0 || req_ch.valid || reading_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            reading_q.push_back(compensate(req_ch.raw_pressure, req_ch.raw_temperature));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (raw_q.size() != 0) begin
               send_beat = raw_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.raw_pressure <= send_beat.pressure;
               req_ch.raw_temperature <= send_beat.temperature;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern plus requested long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_tick++;
         if (hold_left == 0 && holds_taken < holds_asked) begin
            holds_taken++;
            hold_left = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               READY_ALWAYS:   rsp_ch.ready <= 1'b1;
               READY_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               READY_PERIODIC: rsp_ch.ready <= (stall_tick % 4 != 0);
               default:        rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reading_q.size() == 0) begin
            $error("unexpected rsp beat: comp_count %0d", rsp_ch.comp_count);
            failures++;
         end else begin
            want = reading_q.pop_front();
            if (rsp_ch.comp_count !== want.comp_count) begin
               $error("comp_count: expected %0d, got %0d", want.comp_count, rsp_ch.comp_count);
               failures++;
            end
            if (rsp_ch.pressure_kpa !== want.pressure_kpa) begin
               $error("pressure_kpa: expected %0d, got %0d",
                      want.pressure_kpa, rsp_ch.pressure_kpa);
               failures++;
            end
            if (rsp_ch.pressure_low !== want.pressure_low) begin
               $error("pressure_low: expected %0d, got %0d",
                      want.pressure_low, rsp_ch.pressure_low);
               failures++;
            end
         end
      end
   end

   initial begin
      logic [psc_pkg::LimW-1:0] lim;
      req_ch.valid = 1'b0;
      req_ch.raw_pressure = '0;
      req_ch.raw_temperature = '0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coefficients straight out of reset
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FC0);
      wait_idle();

      // typical calibration, field extremes and ignored low bits
      load_coefficients(16'sh3ECE, 16'shB3F9, 16'shC517, 16'sh33C8, 16'sh0010, 16'shFFF0,
                        8'd80);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h003F, 16'h003F);
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'hFFC0, 16'hFFC0);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'h0040, 16'h0040);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h7FFF, 16'h7FFF);
      queue_pair(16'h5555, 16'hAAAA);
      queue_pair(16'hAAAA, 16'h5555);
      queue_pair(16'h6600, 16'h8240);
      queue_pair(16'h9A40, 16'h7E80);
      wait_idle();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: lim = 8'd255;
            1: lim = 8'd0;
            2: lim = 8'd50;
            3: lim = 8'd115;
            4: lim = 8'd116;
            default: lim = psc_pkg::LimW'($urandom_range(45, 120));
         endcase
         load_coefficients(pick_coef(phase), pick_coef(phase), pick_coef(phase),
                           pick_coef(phase), pick_coef(phase), pick_coef(phase), lim);
         for (int i = 0; i < PhaseBeats; i++)
            queue_pair(pick_raw(), pick_raw());
         if (phase == 2)
            holds_asked++;
         wait_idle();
      end

      for (int n = 0; n < 2000 && reading_q.size() != 0; n++)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (reading_q.size() != 0) begin
         $error("%0d rsp beats never arrived", reading_q.size());
         failures++;
      end
      if (failures == 0) begin
         $display("[pressure_sensor_compensation_core] OK");
      end else begin
         $display("[pressure_sensor_compensation_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[pressure_sensor_compensation_core] ERROR");
      $finish;
   end

endmodule
